/* src/superio_config_registers_assert.svh */
// Assertion macros shared by the configuration register block.
// Each macro samples on clk; the first ignores cycles in reset, the second does not.
`ifndef SUPERIO_CONFIG_REGISTERS_ASSERT_SVH
`define SUPERIO_CONFIG_REGISTERS_ASSERT_SVH

`define SIO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define SIO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/sio_cfg_pkg.sv */
// Types, codes and decode functions for the configuration register block.
// Used by sio_cfg_regfile, sio_cfg_decode, the top level and the testbench; depends on nothing.
`default_nettype none

package sio_cfg_pkg;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic {
    PORT_INDEX = 1'b0,
    PORT_DATA  = 1'b1
  } port_t;

  localparam logic [7:0] UNLOCK_KEY    = 8'h55;
  localparam logic [7:0] LOCK_KEY      = 8'hAA;
  localparam logic [7:0] IDLE_BYTE     = 8'hFF;
  localparam logic [7:0] CHIP_ID_RESET = 8'd101;

  localparam int REG_PORTS   = 1;
  localparam int REG_UART    = 2;
  localparam int REG_FDC     = 3;
  localparam int REG_DRIVE   = 5;
  localparam int REG_CHIP_ID = 13;

  // one bus access as held in the input register
  typedef struct packed {
    logic       opcode;
    logic       port_select;
    logic [7:0] write_data;
  } acc_t;

  // registers that feed the decoded settings
  typedef struct packed {
    logic [7:0] ports;
    logic [7:0] uart;
    logic [7:0] fdc;
    logic [7:0] drive;
  } snap_t;

  typedef struct packed {
    logic [9:0] base;
    logic [3:0] irq;
  } uart_t;

  typedef struct packed {
    uart_t      uart_a;
    logic       uart_a_enabled;
    uart_t      uart_b;
    logic       uart_b_enabled;
    logic [9:0] lpt_base;
    logic       fdc_enhanced;
    logic [1:0] densel_force;
    logic       drive_swap;
  } settings_t;

  function automatic logic [7:0] reg_reset(input int idx);
    logic [7:0] v;
    case (idx)
      0:           v = 8'h3A;
      1:           v = 8'h9F;
      2:           v = 8'hDC;
      3:           v = 8'h78;
      6:           v = 8'hFF;
      REG_CHIP_ID: v = CHIP_ID_RESET;
      14:          v = 8'h01;
      default:     v = 8'h00;
    endcase
    return v;
  endfunction

  // pair selects the COM3/COM4 address set
  function automatic uart_t decode_uart(input logic [1:0] sel, input logic [1:0] pair);
    uart_t u;
    logic [9:0] com3;
    logic [9:0] com4;
    case (pair)
      2'd0:    begin com3 = 10'h338; com4 = 10'h238; end
      2'd1:    begin com3 = 10'h3E8; com4 = 10'h2E8; end
      2'd2:    begin com3 = 10'h3E8; com4 = 10'h2E0; end
      default: begin com3 = 10'h220; com4 = 10'h228; end
    endcase
    case (sel)
      2'd0:    begin u.base = 10'h3F8; u.irq = 4'd4; end
      2'd1:    begin u.base = 10'h2F8; u.irq = 4'd3; end
      2'd2:    begin u.base = com3;    u.irq = 4'd4; end
      default: begin u.base = com4;    u.irq = 4'd3; end
    endcase
    return u;
  endfunction

  function automatic logic [9:0] decode_lpt(input logic [1:0] sel);
    logic [9:0] b;
    case (sel)
      2'd0:    b = 10'h000;
      2'd1:    b = 10'h3BC;
      2'd2:    b = 10'h378;
      default: b = 10'h278;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* src/sio_cfg_regfile.sv */
// Lock sequence, index register and setting register file.
// Applies one access per advance and exposes the updated values; uses sio_cfg_pkg.
`default_nettype none

module sio_cfg_regfile #(
  parameter int REG_COUNT = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 adv,
  input  sio_cfg_pkg::acc_t   acc,
  input  wire                 cfg_write,
  input  wire  [7:0]          cfg_data,
  output logic [7:0]          rd_data,
  output logic                mode_next,
  output sio_cfg_pkg::snap_t  snap
);
  import sio_cfg_pkg::*;

  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [8:0] COUNT_W = 9'(REG_COUNT);

  logic [7:0] unlock_older;
  logic [7:0] unlock_older_next;
  logic [7:0] unlock_newer;
  logic [7:0] unlock_newer_next;
  logic [7:0] reg_index;
  logic [7:0] reg_index_next;
  logic [7:0] setting_file      [REG_COUNT];
  logic [7:0] setting_file_next [REG_COUNT];

  logic             unlocked;
  logic             in_range;
  logic             is_write;
  logic             is_data;
  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign unlocked = (unlock_older == UNLOCK_KEY) && (unlock_newer == UNLOCK_KEY);
  assign in_range = {1'b0, reg_index} < COUNT_W;
  assign idx      = reg_index[IDX_W-1:0];
  assign is_write = acc.opcode == OP_WRITE;
  assign is_data  = acc.port_select == PORT_DATA;
  assign wr_en    = adv && is_write && is_data && unlocked && in_range;

  always_comb begin
    unlock_older_next = unlock_older;
    unlock_newer_next = unlock_newer;
    reg_index_next    = reg_index;
    if (adv && is_write && !is_data) begin
      // in config mode only the exit key shifts into the lock pair
      if (unlocked && acc.write_data != LOCK_KEY) begin
        reg_index_next = acc.write_data;
      end else begin
        unlock_older_next = unlock_newer;
        unlock_newer_next = acc.write_data;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < REG_COUNT; i++) begin
      setting_file_next[i] = setting_file[i];
      if (wr_en && idx == IDX_W'(i)) begin
        setting_file_next[i] = acc.write_data;
      end else if (cfg_write && i == REG_CHIP_ID) begin
        setting_file_next[i] = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_older <= '0;
      unlock_newer <= '0;
      reg_index    <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        setting_file[i] <= reg_reset(i);
      end
    end else begin
      unlock_older <= unlock_older_next;
      unlock_newer <= unlock_newer_next;
      reg_index    <= reg_index_next;
      for (int i = 0; i < REG_COUNT; i++) begin
        setting_file[i] <= setting_file_next[i];
      end
    end
  end

  always_comb begin
    rd_data = IDLE_BYTE;
    if (!is_write && is_data && unlocked && in_range) begin
      rd_data = setting_file[idx];
    end
  end

  assign mode_next  = (unlock_older_next == UNLOCK_KEY) && (unlock_newer_next == UNLOCK_KEY);
  assign snap.ports = setting_file_next[REG_PORTS];
  assign snap.uart  = setting_file_next[REG_UART];
  assign snap.fdc   = setting_file_next[REG_FDC];
  assign snap.drive = setting_file_next[REG_DRIVE];

endmodule

`default_nettype wire

/* src/sio_cfg_decode.sv */
// Decodes the serial, parallel and floppy settings from the register snapshot.
// Pure combinational logic; uses sio_cfg_pkg.
`default_nettype none

module sio_cfg_decode (
  input  sio_cfg_pkg::snap_t     snap,
  output sio_cfg_pkg::settings_t settings
);
  import sio_cfg_pkg::*;

  logic [1:0] pair;

  assign pair = snap.ports[6:5];

  always_comb begin
    settings.uart_a         = decode_uart(snap.uart[1:0], pair);
    settings.uart_a_enabled = snap.uart[2];
    settings.uart_b         = decode_uart(snap.uart[5:4], pair);
    settings.uart_b_enabled = snap.uart[6];
    settings.lpt_base       = decode_lpt(snap.ports[1:0]);
    settings.fdc_enhanced   = snap.fdc[1];
    settings.densel_force   = snap.drive[4:3];
    settings.drive_swap     = snap.drive[5];
  end

endmodule

`default_nettype wire

/* src/superio_config_registers.sv */
// Top level of the index/data configuration port: input register, update stage, result register.
// Instantiates sio_cfg_regfile and sio_cfg_decode; uses sio_cfg_pkg and the assertion header.
`default_nettype none

// Each accepted word is one bus access. It lands in an input register, and when it advances
// the lock pair, index and setting registers are updated and the read data plus all decoded
// settings are captured in the result register at the same edge; a stalled result holds it back.
// One word is accepted every cycle while in_stall is low; the rate is set by the single
// register-file access in the update stage. A result waiting under stall does not block the
// input register, which holds one more word before in_stall rises. No clearing pass follows
// reset.
module superio_config_registers #(
  parameter int REG_COUNT = 16
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        opcode,
  input  wire        port_select,
  input  wire  [7:0] write_data,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] read_data,
  output logic       config_mode,
  output logic [9:0] uart_a_base,
  output logic [3:0] uart_a_irq,
  output logic       uart_a_enabled,
  output logic [9:0] uart_b_base,
  output logic [3:0] uart_b_irq,
  output logic       uart_b_enabled,
  output logic [9:0] lpt_base,
  output logic       fdc_enhanced,
  output logic [1:0] densel_force,
  output logic       drive_swap,
  input  wire        cfg_write,
  input  wire  [7:0] cfg_data
);
  import sio_cfg_pkg::*;

  logic      s1_valid;
  acc_t      s1_acc;
  logic      s1_adv;
  logic      in_take;
  logic [7:0] rd_data;
  logic      mode_next;
  snap_t     snap;
  settings_t settings_next;
  settings_t settings;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_acc <= '{opcode: opcode, port_select: port_select, write_data: write_data};
    end
  end

  sio_cfg_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .adv       (s1_adv),
    .acc       (s1_acc),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .rd_data   (rd_data),
    .mode_next (mode_next),
    .snap      (snap)
  );

  sio_cfg_decode u_decode (
    .snap     (snap),
    .settings (settings_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_data   <= rd_data;
      config_mode <= mode_next;
      settings    <= settings_next;
    end
  end

  assign uart_a_base    = settings.uart_a.base;
  assign uart_a_irq     = settings.uart_a.irq;
  assign uart_a_enabled = settings.uart_a_enabled;
  assign uart_b_base    = settings.uart_b.base;
  assign uart_b_irq     = settings.uart_b.irq;
  assign uart_b_enabled = settings.uart_b_enabled;
  assign lpt_base       = settings.lpt_base;
  assign fdc_enhanced   = settings.fdc_enhanced;
  assign densel_force   = settings.densel_force;
  assign drive_swap     = settings.drive_swap;

`include "superio_config_registers_assert.svh"

  `SIO_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")
  `SIO_ASSERT(a_stall_cause, in_stall |-> (s1_valid && out_valid && out_stall), "bad stall")
  `SIO_ASSERT(a_stage_moves, (s1_valid && !in_stall) |=> out_valid, "access lost in stage")
  `SIO_ASSERT(a_read_mode, (out_valid && read_data != IDLE_BYTE) |-> config_mode, "data while locked")

endmodule

`default_nettype wire

/* verif/superio_config_registers_tb.sv */
// Self-checking testbench for superio_config_registers: index/data port accesses with random
// idling on both sides, checked against an in-bench predictor of the register file and decode.
// Depends on sio_cfg_pkg and the top level only.
`timescale 1ns / 100ps

module superio_config_registers_tb;
  import sio_cfg_pkg::*;

  localparam int NUM_REGS = 16;
  localparam int SEL_W = $clog2(NUM_REGS);
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [7:0] read_data;
    logic       config_mode;
    logic [9:0] uart_a_base;
    logic [3:0] uart_a_irq;
    logic       uart_a_enabled;
    logic [9:0] uart_b_base;
    logic [3:0] uart_b_irq;
    logic       uart_b_enabled;
    logic [9:0] lpt_base;
    logic       fdc_enhanced;
    logic [1:0] densel_force;
    logic       drive_swap;
  } port_view_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic opcode;
  logic port_select;
  logic [7:0] write_data;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] read_data;
  logic config_mode;
  logic [9:0] uart_a_base;
  logic [3:0] uart_a_irq;
  logic uart_a_enabled;
  logic [9:0] uart_b_base;
  logic [3:0] uart_b_irq;
  logic uart_b_enabled;
  logic [9:0] lpt_base;
  logic fdc_enhanced;
  logic [1:0] densel_force;
  logic drive_swap;
  logic cfg_write;
  logic [7:0] cfg_data;

  // predictor state
  logic [7:0] chip_value;
  logic [7:0] key_older;
  logic [7:0] key_newer;
  logic [7:0] sel_index;
  logic [7:0] setting_regs [NUM_REGS];

  port_view_t pending_views[$];
  int error_count = 0;
  int accesses_sent = 0;
  int in_gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  superio_config_registers #(.REG_COUNT(NUM_REGS)) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .port_select    (port_select),
    .write_data     (write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .config_mode    (config_mode),
    .uart_a_base    (uart_a_base),
    .uart_a_irq     (uart_a_irq),
    .uart_a_enabled (uart_a_enabled),
    .uart_b_base    (uart_b_base),
    .uart_b_irq     (uart_b_irq),
    .uart_b_enabled (uart_b_enabled),
    .lpt_base       (lpt_base),
    .fdc_enhanced   (fdc_enhanced),
    .densel_force   (densel_force),
    .drive_swap     (drive_swap),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void reset_state();
    chip_value = CHIP_ID_RESET;
    key_older = 8'h00;
    key_newer = 8'h00;
    sel_index = 8'h00;
    for (int i = 0; i < NUM_REGS; i++) setting_regs[i] = 8'h00;
    setting_regs[0] = 8'h3A;
    setting_regs[REG_PORTS] = 8'h9F;
    setting_regs[REG_UART] = 8'hDC;
    setting_regs[REG_FDC] = 8'h78;
    setting_regs[6] = 8'hFF;
    setting_regs[REG_CHIP_ID] = chip_value;
    setting_regs[14] = 8'h01;
  endfunction

  function automatic logic unlocked_now();
    return key_older == UNLOCK_KEY && key_newer == UNLOCK_KEY;
  endfunction

  // {base, irq} of one serial port; pair picks the alternate COM3/COM4 addresses
  function automatic logic [13:0] serial_map(logic [1:0] sel, logic [1:0] pair);
    logic [9:0] alt_base;
    if (sel == 2'd2) begin
      case (pair)
        2'd0:    alt_base = 10'h338;
        2'd3:    alt_base = 10'h220;
        default: alt_base = 10'h3E8;
      endcase
    end else begin
      case (pair)
        2'd0:    alt_base = 10'h238;
        2'd1:    alt_base = 10'h2E8;
        2'd2:    alt_base = 10'h2E0;
        default: alt_base = 10'h228;
      endcase
    end
    case (sel)
      2'd0:    return {10'h3F8, 4'd4};
      2'd1:    return {10'h2F8, 4'd3};
      2'd2:    return {alt_base, 4'd4};
      default: return {alt_base, 4'd3};
    endcase
  endfunction

  function automatic port_view_t apply_access(op_t op, port_t port, logic [7:0] wd);
    port_view_t v;
    logic [7:0] ports_r;
    logic [7:0] uart_r;
    v.read_data = IDLE_BYTE;
    if (op == OP_WRITE) begin
      if (unlocked_now()) begin
        if (port == PORT_INDEX) begin
          if (wd == LOCK_KEY) begin
            key_older = key_newer;
            key_newer = wd;
          end else begin
            sel_index = wd;
          end
        end else if (sel_index < NUM_REGS) begin
          setting_regs[sel_index[SEL_W-1:0]] = wd;
        end
      end else if (port == PORT_INDEX) begin
        key_older = key_newer;
        key_newer = wd;
      end
    end else if (unlocked_now() && port == PORT_DATA && sel_index < NUM_REGS) begin
      v.read_data = setting_regs[sel_index[SEL_W-1:0]];
    end
    ports_r = setting_regs[REG_PORTS];
    uart_r = setting_regs[REG_UART];
    v.config_mode = unlocked_now();
    {v.uart_a_base, v.uart_a_irq} = serial_map(uart_r[1:0], ports_r[6:5]);
    v.uart_a_enabled = uart_r[2];
    {v.uart_b_base, v.uart_b_irq} = serial_map(uart_r[5:4], ports_r[6:5]);
    v.uart_b_enabled = uart_r[6];
    case (ports_r[1:0])
      2'd0:    v.lpt_base = 10'h000;
      2'd1:    v.lpt_base = 10'h3BC;
      2'd2:    v.lpt_base = 10'h378;
      default: v.lpt_base = 10'h278;
    endcase
    v.fdc_enhanced = setting_regs[REG_FDC][1];
    v.densel_force = setting_regs[REG_DRIVE][4:3];
    v.drive_swap = setting_regs[REG_DRIVE][5];
    return v;
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  task automatic send_access(input op_t op, input port_t port, input logic [7:0] data);
    int gap;
    in_valid <= 1'b1;
    opcode <= op;
    port_select <= port;
    write_data <= data;
    @(negedge clk);
    while (in_stall !== 1'b0) @(negedge clk);
    @(posedge clk);
    pending_views.push_back(apply_access(op, port, data));
    accesses_sent++;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      gap = pause_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic enter_mode();
    send_access(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
    send_access(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
  endtask

  // drop valid and wait until every word has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_chip_id(input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    chip_value = value;
    setting_regs[REG_CHIP_ID] = value;
  endtask

  task automatic test_locked_port();
    send_access(OP_READ, PORT_INDEX, 8'h00);
    send_access(OP_READ, PORT_DATA, 8'hFF);
    send_access(OP_WRITE, PORT_DATA, 8'hFF);
    // a single key followed by another byte must not unlock
    send_access(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
    send_access(OP_WRITE, PORT_INDEX, 8'h00);
  endtask

  task automatic test_unlock_and_select();
    // reads between the two keys leave the lock pair alone
    send_access(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
    send_access(OP_READ, PORT_INDEX, 8'h00);
    send_access(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
    send_access(OP_READ, PORT_DATA, 8'h00);
    send_access(OP_READ, PORT_INDEX, 8'h00);
    send_access(OP_WRITE, PORT_INDEX, 8'(REG_UART));
    send_access(OP_WRITE, PORT_DATA, 8'h00);
    send_access(OP_WRITE, PORT_DATA, 8'hFF);
    send_access(OP_WRITE, PORT_INDEX, 8'(REG_PORTS));
    send_access(OP_WRITE, PORT_DATA, 8'hFF);
    send_access(OP_READ, PORT_DATA, 8'h00);
    send_access(OP_WRITE, PORT_INDEX, 8'(REG_DRIVE));
    send_access(OP_WRITE, PORT_DATA, 8'hFF);
  endtask

  task automatic test_index_out_of_range();
    send_access(OP_WRITE, PORT_INDEX, 8'hFF);
    send_access(OP_WRITE, PORT_DATA, 8'h00);
    send_access(OP_READ, PORT_DATA, 8'h00);
    send_access(OP_WRITE, PORT_INDEX, 8'(NUM_REGS));
    send_access(OP_READ, PORT_DATA, 8'h00);
  endtask

  task automatic test_lock_exit();
    send_access(OP_WRITE, PORT_INDEX, LOCK_KEY);
    send_access(OP_READ, PORT_DATA, 8'h00);
  endtask

  task automatic test_chip_id(input logic [7:0] value);
    settle();
    write_chip_id(value);
    enter_mode();
    send_access(OP_WRITE, PORT_INDEX, 8'(REG_CHIP_ID));
    send_access(OP_READ, PORT_DATA, 8'h00);
    send_access(OP_WRITE, PORT_DATA, ~value);
    send_access(OP_READ, PORT_DATA, 8'h00);
    send_access(OP_WRITE, PORT_INDEX, LOCK_KEY);
  endtask

  function automatic logic [7:0] pick_reg();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      case ($urandom_range(0, 3))
        0:       return 8'(REG_PORTS);
        1:       return 8'(REG_UART);
        2:       return 8'(REG_FDC);
        default: return 8'(REG_DRIVE);
      endcase
    end
    if (r < 8) return 8'($urandom_range(0, NUM_REGS - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_random_traffic(input int count, input int gap_pct, input int busy_pct,
                                     input bit vary);
    int target;
    int kind;
    target = accesses_sent + count;
    in_gap_pct = gap_pct;
    stall_pct = busy_pct;
    while (accesses_sent < target) begin
      if (vary) begin
        in_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // well-formed session: unlock, a few register accesses, usually lock again
        enter_mode();
        repeat ($urandom_range(1, 8)) begin
          send_access(OP_WRITE, PORT_INDEX, pick_reg());
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 7) == 0)
              send_access(OP_READ, PORT_INDEX, 8'($urandom));
            else if ($urandom_range(0, 2) == 0)
              send_access(OP_READ, PORT_DATA, 8'($urandom));
            else
              send_access(OP_WRITE, PORT_DATA, 8'($urandom));
          end
        end
        if ($urandom_range(0, 4) != 0) send_access(OP_WRITE, PORT_INDEX, LOCK_KEY);
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 6))
          send_access(op_t'($urandom_range(0, 1)), port_t'($urandom_range(0, 1)),
                      8'($urandom));
      end else begin
        // broken or interrupted key sequences
        send_access(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
        if ($urandom_range(0, 1) == 0)
          send_access(OP_WRITE, PORT_INDEX, 8'($urandom));
        else
          send_access(OP_READ, port_t'($urandom_range(0, 1)), 8'($urandom));
        send_access(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
        send_access(OP_READ, PORT_DATA, 8'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= pause_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // a word seen here with stall low is taken at the next rising edge
  always @(negedge clk) begin : check_results
    port_view_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_views.size() == 0) begin
        $display("%0t: result word with no access outstanding", $time);
        error_count++;
      end else begin
        want = pending_views.pop_front();
        check_field("read_data", 10'(want.read_data), 10'(read_data));
        check_field("config_mode", 10'(want.config_mode), 10'(config_mode));
        check_field("uart_a_base", want.uart_a_base, uart_a_base);
        check_field("uart_a_irq", 10'(want.uart_a_irq), 10'(uart_a_irq));
        check_field("uart_a_enabled", 10'(want.uart_a_enabled), 10'(uart_a_enabled));
        check_field("uart_b_base", want.uart_b_base, uart_b_base);
        check_field("uart_b_irq", 10'(want.uart_b_irq), 10'(uart_b_irq));
        check_field("uart_b_enabled", 10'(want.uart_b_enabled), 10'(uart_b_enabled));
        check_field("lpt_base", want.lpt_base, lpt_base);
        check_field("fdc_enhanced", 10'(want.fdc_enhanced), 10'(fdc_enhanced));
        check_field("densel_force", 10'(want.densel_force), 10'(densel_force));
        check_field("drive_swap", 10'(want.drive_swap), 10'(drive_swap));
      end
    end
  end

  // end the run when neither channel moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    opcode <= OP_READ;
    port_select <= PORT_INDEX;
    write_data <= 8'h00;
    cfg_write <= 1'b0;
    cfg_data <= 8'h00;
    reset_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_chip_id(8'h00);
    in_gap_pct = 20;
    stall_pct = 20;
    test_locked_port();
    test_unlock_and_select();
    test_index_out_of_range();
    test_lock_exit();
    test_chip_id(8'hFF);

    settle();
    test_random_traffic(300, 0, 0, 1'b0);
    settle();
    write_chip_id(8'($urandom));
    test_random_traffic(300, 40, 40, 1'b0);
    settle();
    write_chip_id(8'($urandom));
    test_random_traffic(330, 0, 0, 1'b1);
    settle();
    repeat (8) @(posedge clk);

    if (pending_views.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, pending_views.size());
      error_count++;
    end
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/sio_cfg_pkg.sv
src/sio_cfg_regfile.sv
src/sio_cfg_decode.sv
src/superio_config_registers.sv
verif/superio_config_registers_tb.sv
